FILE: hw/rtl/mac_keyed_node_table_core_defines.svh
// assertion macros used by the node table rtl
`ifndef MAC_KEYED_NODE_TABLE_CORE_DEFINES_SVH
`define MAC_KEYED_NODE_TABLE_CORE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define MKN_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define MKN_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/mkn_pkg.sv
// shared widths, codes, states and result type of the node table
package mkn_pkg;

  localparam int CMD_W         = 3;
  localparam int ID_W          = 5;
  localparam int MAC_W         = 48;
  localparam int ST_W          = 3;
  localparam int CNT_W         = 6;
  localparam int ENTRY_W       = ST_W + MAC_W;
  localparam int DEFAULT_SLOTS = 32;

  localparam logic [CNT_W-1:0] COUNT_MAX = 6'd63;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOOKUP     = 3'd0,
    CMD_ALLOC      = 3'd1,
    CMD_UNREG_ID   = 3'd2,
    CMD_UNREG_MAC  = 3'd3,
    CMD_COUNT      = 3'd4,
    CMD_NEXT       = 3'd5,
    CMD_SET_STATUS = 3'd6,
    CMD_READ       = 3'd7
  } cmd_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_SCAN_TAIL,
    ST_FINISH,
    ST_RD,
    ST_RMW,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic             found;
    logic [ID_W-1:0]  result_id;
    logic [ST_W-1:0]  slot_status;
    logic [MAC_W-1:0] slot_mac;
    logic [CNT_W-1:0] active_count;
  } result_t;

endpackage

FILE: hw/rtl/mkn_mem.sv
// single-port slot memory, {status, mac} per entry, registered read
module mkn_mem import mkn_pkg::*; #(
  parameter int SLOTS = DEFAULT_SLOTS
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(SLOTS)-1:0] addr,
  input  logic [ENTRY_W-1:0]       wdata,
  output logic [ENTRY_W-1:0]       rdata
);

  logic [ENTRY_W-1:0] mem_r [SLOTS];
  logic [ENTRY_W-1:0] rdata_r;

  // one access per cycle, write or read
  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem_r[addr] <= wdata;
      end else begin
        rdata_r <= mem_r[addr];
      end
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: hw/rtl/mkn_ctrl.sv
// command sequencer: memory scan, read-modify-write and clearing pass
`include "mac_keyed_node_table_core_defines.svh"

module mkn_ctrl import mkn_pkg::*; #(
  parameter int SLOTS = DEFAULT_SLOTS
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_tvalid,
  output logic                     in_tready,
  input  cmd_t                     in_cmd,
  input  logic [ID_W-1:0]          in_node_id,
  input  logic [MAC_W-1:0]         in_mac,
  input  logic [ST_W-1:0]          in_new_status,
  output logic                     res_valid,
  input  logic                     res_ready,
  output result_t                  res,
  output logic                     mem_en,
  output logic                     mem_we,
  output logic [$clog2(SLOTS)-1:0] mem_addr,
  output logic [ENTRY_W-1:0]       mem_wdata,
  input  logic [ENTRY_W-1:0]       mem_rdata
);

  localparam int IDX_W = $clog2(SLOTS);
  localparam int CMPW  = ((IDX_W > ID_W) ? IDX_W : ID_W) + 1;
  localparam int CNTW  = $clog2(SLOTS + 1);
  localparam int CSW   = (CNTW > CNT_W) ? CNTW : CNT_W;

  state_t           state_r, state_nxt;
  logic [IDX_W-1:0] scan_addr_r, scan_addr_nxt;
  logic             rd_vld_r, rd_vld_nxt;
  logic [IDX_W-1:0] rd_idx_r, rd_idx_nxt;

  cmd_t             cmd_r, cmd_nxt;
  logic [ID_W-1:0]  id_r, id_nxt;
  logic [MAC_W-1:0] mac_r, mac_nxt;
  logic [ST_W-1:0]  nst_r, nst_nxt;

  logic             hit_r, hit_nxt;
  logic [IDX_W-1:0] hit_idx_r, hit_idx_nxt;
  logic [ST_W-1:0]  hit_st_r, hit_st_nxt;
  logic [MAC_W-1:0] hit_mac_r, hit_mac_nxt;
  logic             free_r, free_nxt;
  logic [IDX_W-1:0] free_idx_r, free_idx_nxt;
  logic [CNTW-1:0]  cnt_r, cnt_nxt;
  result_t          res_r, res_nxt;

  logic [ST_W-1:0]  rd_st;
  logic [MAC_W-1:0] rd_mac;
  logic             scan_vld;
  logic             key_hit;
  logic             next_hit;
  logic             sel_hit;
  logic             scan_last;
  logic             in_range;
  logic [CSW-1:0]   cnt_ext;
  logic [CNT_W-1:0] cnt_sat;

  // entry fields and per-entry scan conditions
  assign rd_st     = mem_rdata[ENTRY_W-1:MAC_W];
  assign rd_mac    = mem_rdata[MAC_W-1:0];
  assign scan_vld  = rd_vld_r && (state_r == ST_SCAN || state_r == ST_SCAN_TAIL);
  assign key_hit   = (rd_st != '0) && (rd_mac == mac_r);
  assign next_hit  = (rd_st != '0) && (CMPW'(rd_idx_r) > CMPW'(id_r));
  assign sel_hit   = (cmd_r == CMD_NEXT) ? next_hit : key_hit;
  assign scan_last = (scan_addr_r == IDX_W'(SLOTS - 1));
  assign in_range  = (CMPW'(in_node_id) < CMPW'(SLOTS));

  // count saturates at the output field width
  assign cnt_ext = CSW'(cnt_r);
  assign cnt_sat = (cnt_ext > CSW'(COUNT_MAX)) ? COUNT_MAX : CNT_W'(cnt_ext);

  // state and control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      scan_addr_r <= '0;
      rd_vld_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      scan_addr_r <= scan_addr_nxt;
      rd_vld_r    <= rd_vld_nxt;
    end
  end

  // command and scan payload registers
  always_ff @(posedge clk) begin
    rd_idx_r   <= rd_idx_nxt;
    cmd_r      <= cmd_nxt;
    id_r       <= id_nxt;
    mac_r      <= mac_nxt;
    nst_r      <= nst_nxt;
    hit_r      <= hit_nxt;
    hit_idx_r  <= hit_idx_nxt;
    hit_st_r   <= hit_st_nxt;
    hit_mac_r  <= hit_mac_nxt;
    free_r     <= free_nxt;
    free_idx_r <= free_idx_nxt;
    cnt_r      <= cnt_nxt;
    res_r      <= res_nxt;
  end

  // next state, memory access and result
  always_comb begin
    state_nxt     = state_r;
    scan_addr_nxt = scan_addr_r;
    rd_vld_nxt    = 1'b0;
    rd_idx_nxt    = rd_idx_r;
    cmd_nxt       = cmd_r;
    id_nxt        = id_r;
    mac_nxt       = mac_r;
    nst_nxt       = nst_r;
    hit_nxt       = hit_r;
    hit_idx_nxt   = hit_idx_r;
    hit_st_nxt    = hit_st_r;
    hit_mac_nxt   = hit_mac_r;
    free_nxt      = free_r;
    free_idx_nxt  = free_idx_r;
    cnt_nxt       = cnt_r;
    res_nxt       = res_r;
    mem_en        = 1'b0;
    mem_we        = 1'b0;
    mem_addr      = scan_addr_r;
    mem_wdata     = '0;
    in_tready     = 1'b0;
    res_valid     = 1'b0;

    // fold returned entries into lowest hit, lowest free slot and count
    if (scan_vld && sel_hit && !hit_r) begin
      hit_nxt     = 1'b1;
      hit_idx_nxt = rd_idx_r;
      hit_st_nxt  = rd_st;
      hit_mac_nxt = rd_mac;
    end
    if (scan_vld && (rd_st == '0) && !free_r) begin
      free_nxt     = 1'b1;
      free_idx_nxt = rd_idx_r;
    end
    if (scan_vld && (rd_st != '0)) begin
      cnt_nxt = cnt_r + CNTW'(1);
    end

    case (state_r)
      ST_CLEAR: begin
        mem_en   = 1'b1;
        mem_we   = 1'b1;
        mem_addr = scan_addr_r;
        if (scan_last) begin
          scan_addr_nxt = '0;
          state_nxt     = ST_IDLE;
        end else begin
          scan_addr_nxt = scan_addr_r + IDX_W'(1);
        end
      end
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd_nxt       = in_cmd;
          id_nxt        = in_node_id;
          mac_nxt       = in_mac;
          nst_nxt       = in_new_status;
          hit_nxt       = 1'b0;
          free_nxt      = 1'b0;
          cnt_nxt       = '0;
          res_nxt       = '0;
          scan_addr_nxt = '0;
          case (in_cmd)
            CMD_UNREG_ID, CMD_SET_STATUS, CMD_READ: begin
              state_nxt = in_range ? ST_RD : ST_DONE;
            end
            default: begin
              state_nxt = ST_SCAN;
            end
          endcase
        end
      end
      ST_SCAN: begin
        mem_en     = 1'b1;
        mem_addr   = scan_addr_r;
        rd_vld_nxt = 1'b1;
        rd_idx_nxt = scan_addr_r;
        if (scan_last) begin
          scan_addr_nxt = '0;
          state_nxt     = ST_SCAN_TAIL;
        end else begin
          scan_addr_nxt = scan_addr_r + IDX_W'(1);
        end
      end
      ST_SCAN_TAIL: begin
        state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        state_nxt = ST_DONE;
        case (cmd_r)
          CMD_LOOKUP, CMD_NEXT: begin
            if (hit_r) begin
              res_nxt.found       = 1'b1;
              res_nxt.result_id   = ID_W'(hit_idx_r);
              res_nxt.slot_status = hit_st_r;
              res_nxt.slot_mac    = hit_mac_r;
            end
          end
          CMD_ALLOC: begin
            if (hit_r) begin
              res_nxt.found       = 1'b1;
              res_nxt.result_id   = ID_W'(hit_idx_r);
              res_nxt.slot_status = hit_st_r;
              res_nxt.slot_mac    = hit_mac_r;
            end else if (free_r) begin
              // claim the lowest free slot, status stays unregistered
              mem_en              = 1'b1;
              mem_we              = 1'b1;
              mem_addr            = free_idx_r;
              mem_wdata           = {{ST_W{1'b0}}, mac_r};
              res_nxt.found       = 1'b1;
              res_nxt.result_id   = ID_W'(free_idx_r);
              res_nxt.slot_mac    = mac_r;
            end
          end
          CMD_UNREG_MAC: begin
            if (hit_r) begin
              mem_en            = 1'b1;
              mem_we            = 1'b1;
              mem_addr          = hit_idx_r;
              res_nxt.found     = 1'b1;
              res_nxt.result_id = ID_W'(hit_idx_r);
            end
          end
          CMD_COUNT: begin
            res_nxt.active_count = cnt_sat;
          end
          default: begin
          end
        endcase
      end
      ST_RD: begin
        mem_en     = 1'b1;
        mem_addr   = IDX_W'(id_r);
        rd_vld_nxt = 1'b1;
        rd_idx_nxt = IDX_W'(id_r);
        state_nxt  = ST_RMW;
      end
      ST_RMW: begin
        state_nxt = ST_DONE;
        case (cmd_r)
          CMD_UNREG_ID: begin
            mem_en   = 1'b1;
            mem_we   = 1'b1;
            mem_addr = IDX_W'(id_r);
            if (rd_st != '0) begin
              res_nxt.found     = 1'b1;
              res_nxt.result_id = id_r;
            end
          end
          CMD_SET_STATUS: begin
            mem_en              = 1'b1;
            mem_we              = 1'b1;
            mem_addr            = IDX_W'(id_r);
            mem_wdata           = {nst_r, rd_mac};
            res_nxt.found       = 1'b1;
            res_nxt.result_id   = id_r;
            res_nxt.slot_status = nst_r;
            res_nxt.slot_mac    = rd_mac;
          end
          default: begin
            res_nxt.found       = 1'b1;
            res_nxt.result_id   = id_r;
            res_nxt.slot_status = rd_st;
            res_nxt.slot_mac    = rd_mac;
          end
        endcase
      end
      ST_DONE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign res = res_r;

  // checks
  `MKN_ASSERT_IMP(a_we_state, clk, rst_n, mem_we, state_r == ST_CLEAR || state_r == ST_FINISH || state_r == ST_RMW, "memory write outside clear or update state")
  `MKN_ASSERT_IMP(a_rd_state, clk, rst_n, rd_vld_r, state_r == ST_SCAN || state_r == ST_SCAN_TAIL || state_r == ST_RMW, "read data returned in wrong state")
  `MKN_ASSERT_NXT(a_acc_busy, clk, rst_n, in_tvalid && in_tready, state_r != ST_IDLE && state_r != ST_CLEAR, "accepted command not started")
  `MKN_ASSERT_IMP(a_res_done, clk, rst_n, res_valid, state_r == ST_DONE && !in_tready, "result offered while taking input")

endmodule

FILE: hw/rtl/mac_keyed_node_table_core.sv
// Scan commands (lookup, allocate, unregister by mac, count, next active) read every slot in turn
// through the single memory port (SCAN, SCAN_TAIL); allocate and unregister by mac may then write in FINISH.
// Slot commands (unregister by id, set status, read): one read (RD), then a write-back (RMW) for unregister
// by id and set status; an id past the table skips both. A result goes from FINISH or RMW through DONE.
// Reset is synchronous, active low; a clearing pass then writes zero to every slot,
// and no input transfer is taken until it ends.
module mac_keyed_node_table_core import mkn_pkg::*; #(
  parameter int SLOTS = DEFAULT_SLOTS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [55:0] in_tdata,   // node_id[4:0], mac_addr[52:5], new_status[55:53]
  input  logic [2:0]  in_tuser,   // cmd[2:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata   // found[0], result_id[5:1], slot_status[8:6],
                                  // slot_mac[56:9], active_count[62:57], zero[63]
);

  localparam int IDX_W = $clog2(SLOTS);

  logic               res_valid;
  logic               res_ready;
  result_t            res;
  logic               mem_en;
  logic               mem_we;
  logic [IDX_W-1:0]   mem_addr;
  logic [ENTRY_W-1:0] mem_wdata;
  logic [ENTRY_W-1:0] mem_rdata;

  logic               out_tvalid_r;
  result_t            out_res_r;

  mkn_ctrl #(
    .SLOTS(SLOTS)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_cmd       (cmd_t'(in_tuser[2:0])),
    .in_node_id   (in_tdata[4:0]),
    .in_mac       (in_tdata[52:5]),
    .in_new_status(in_tdata[55:53]),
    .res_valid    (res_valid),
    .res_ready    (res_ready),
    .res          (res),
    .mem_en       (mem_en),
    .mem_we       (mem_we),
    .mem_addr     (mem_addr),
    .mem_wdata    (mem_wdata),
    .mem_rdata    (mem_rdata)
  );

  mkn_mem #(
    .SLOTS(SLOTS)
  ) u_mem (
    .clk  (clk),
    .en   (mem_en),
    .we   (mem_we),
    .addr (mem_addr),
    .wdata(mem_wdata),
    .rdata(mem_rdata)
  );

  // output register, refilled when empty or being drained
  assign res_ready = !out_tvalid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (res_ready) begin
      out_tvalid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {1'b0, out_res_r.active_count, out_res_r.slot_mac,
                       out_res_r.slot_status, out_res_r.result_id, out_res_r.found};

endmodule

FILE: tb/mac_keyed_node_table_core_tb.sv
// testbench for the mac keyed node table core: directed and random command streams checked by a scoreboard
module mac_keyed_node_table_core_tb;
  import mkn_pkg::*;

  localparam int SLOTS        = DEFAULT_SLOTS;
  localparam int RANDOM_ITEMS = 1750;
  localparam int POOL_SIZE    = 40;
  localparam int PAUSE_EVERY  = 300;
  localparam int PHASE_LEN    = 150;

  typedef enum int {
    MIX_ALLOC_PAIR,
    MIX_LOOKUP,
    MIX_UNREG_MAC,
    MIX_UNREG_ID,
    MIX_COUNT,
    MIX_NEXT,
    MIX_SET_STATUS,
    MIX_READ,
    MIX_NOISE
  } mix_kind_t;

  typedef enum int {
    PHASE_FILL,
    PHASE_DRAIN,
    PHASE_MIXED
  } phase_t;

  // shadow table of the node slots plus the answers still owed by the block
  class node_table_model;
    int unsigned      n_slots;
    logic [MAC_W-1:0] mac_mem[];
    logic [ST_W-1:0]  status_mem[];
    result_t          answers_due[$];
    int unsigned      mismatches;

    function new(int unsigned slots);
      n_slots    = slots;
      mac_mem    = new[slots];
      status_mem = new[slots];
      foreach (mac_mem[k]) begin
        mac_mem[k]    = '0;
        status_mem[k] = '0;
      end
      mismatches = 0;
    endfunction

    // lowest registered slot holding mac, n_slots when there is none
    function int unsigned match_mac(logic [MAC_W-1:0] mac);
      for (int unsigned k = 0; k < n_slots; k++) begin
        if (mac_mem[k] == mac && status_mem[k] != '0) return k;
      end
      return n_slots;
    endfunction

    // answer showing one slot, or all zero when the index is past the table
    function result_t slot_view(int unsigned k);
      result_t r;
      r = '0;
      if (k < n_slots) begin
        r.found       = 1'b1;
        r.result_id   = ID_W'(k);
        r.slot_status = status_mem[k];
        r.slot_mac    = mac_mem[k];
      end
      return r;
    endfunction

    // apply one accepted command and queue the answer it must produce
    function result_t take_command(cmd_t cmd, logic [ID_W-1:0] id, logic [MAC_W-1:0] mac,
                                   logic [ST_W-1:0] nst);
      result_t     r;
      int unsigned k;
      int unsigned cnt;
      r = '0;
      case (cmd)
        CMD_LOOKUP: begin
          r = slot_view(match_mac(mac));
        end
        CMD_ALLOC: begin
          k = match_mac(mac);
          if (k >= n_slots) begin
            for (k = 0; k < n_slots; k++) begin
              if (status_mem[k] == '0) break;
            end
            if (k < n_slots) mac_mem[k] = mac;
          end
          r = slot_view(k);
        end
        CMD_UNREG_ID: begin
          if (id < n_slots) begin
            mac_mem[id] = '0;
            if (status_mem[id] != '0) begin
              status_mem[id] = '0;
              r.found        = 1'b1;
              r.result_id    = id;
            end
          end
        end
        CMD_UNREG_MAC: begin
          k = match_mac(mac);
          if (k < n_slots) begin
            mac_mem[k]    = '0;
            status_mem[k] = '0;
            r.found       = 1'b1;
            r.result_id   = ID_W'(k);
          end
        end
        CMD_COUNT: begin
          cnt = 0;
          foreach (status_mem[j]) begin
            if (status_mem[j] != '0) cnt++;
          end
          r.active_count = (cnt > COUNT_MAX) ? COUNT_MAX : CNT_W'(cnt);
        end
        CMD_NEXT: begin
          for (k = id + 1; k < n_slots; k++) begin
            if (status_mem[k] != '0) break;
          end
          r = slot_view(k);
        end
        CMD_SET_STATUS: begin
          if (id < n_slots) status_mem[id] = nst;
          r = slot_view(32'(id));
        end
        default: begin
          r = slot_view(32'(id));
        end
      endcase
      answers_due.push_back(r);
      return r;
    endfunction

    function void report(string field, logic [63:0] want, logic [63:0] got);
      $display("%0t: %s expected %0h actual %0h", $time, field, want, got);
      mismatches++;
    endfunction

    // compare one result transfer with the oldest owed answer
    function void check_answer(logic [63:0] d);
      result_t got;
      result_t want;
      got.found        = d[0];
      got.result_id    = d[5:1];
      got.slot_status  = d[8:6];
      got.slot_mac     = d[56:9];
      got.active_count = d[62:57];
      if (answers_due.size() == 0) begin
        report("unexpected result", '0, d);
        return;
      end
      want = answers_due.pop_front();
      if (got.found !== want.found)
        report("found", 64'(want.found), 64'(got.found));
      if (got.result_id !== want.result_id)
        report("result_id", 64'(want.result_id), 64'(got.result_id));
      if (got.slot_status !== want.slot_status)
        report("slot_status", 64'(want.slot_status), 64'(got.slot_status));
      if (got.slot_mac !== want.slot_mac)
        report("slot_mac", 64'(want.slot_mac), 64'(got.slot_mac));
      if (got.active_count !== want.active_count)
        report("active_count", 64'(want.active_count), 64'(got.active_count));
    endfunction

    function int unsigned pending();
      return answers_due.size();
    endfunction
  endclass

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [55:0] in_tdata   = '0;
  logic [2:0]  in_tuser   = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;

  node_table_model  table_model;
  result_t          last_answer;
  int unsigned      sent_items = 0;
  bit               sender_steady = 1'b0;
  logic [MAC_W-1:0] mac_pool[POOL_SIZE];

  mac_keyed_node_table_core #(
    .SLOTS(SLOTS)
  ) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  // clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic logic [MAC_W-1:0] rand_mac();
    return {16'($urandom), 32'($urandom)};
  endfunction

  function automatic logic [MAC_W-1:0] pool_mac();
    return mac_pool[$urandom_range(0, POOL_SIZE - 1)];
  endfunction

  function automatic logic [ID_W-1:0] rand_id();
    return ID_W'($urandom);
  endfunction

  function automatic logic [ST_W-1:0] rand_st();
    return ST_W'($urandom);
  endfunction

  // one command transfer after a random gap (none while the sender is steady), then the answer is predicted
  task automatic send_command(cmd_t cmd, logic [ID_W-1:0] id, logic [MAC_W-1:0] mac,
                              logic [ST_W-1:0] nst);
    int unsigned gap;
    gap = sender_steady ? 0 : $urandom_range(0, 10);
    repeat (gap) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= {nst, mac, id};
    in_tuser  <= cmd;
    do @(posedge clk); while (!in_tready);
    last_answer = table_model.take_command(cmd, id, mac, nst);
    sent_items++;
    if ($urandom_range(0, 63) == 0) sender_steady = !sender_steady;
  endtask

  // drop valid and wait until every owed answer has come back
  task automatic drain_answers();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (table_model.pending() != 0) @(posedge clk);
  endtask

  // one random command, or an allocate that is usually followed by a status write to the slot it got
  task automatic random_step(phase_t phase);
    int w[9];
    int roll;
    int kind;
    case (phase)
      PHASE_FILL:  w = '{55, 10, 3, 2, 5, 8, 5, 7, 5};
      PHASE_DRAIN: w = '{10, 15, 25, 20, 5, 8, 7, 5, 5};
      default:     w = '{30, 15, 10, 8, 7, 8, 8, 8, 6};
    endcase
    roll = $urandom_range(0, 99);
    kind = 0;
    while (roll >= w[kind]) begin
      roll -= w[kind];
      kind++;
    end
    case (mix_kind_t'(kind))
      MIX_ALLOC_PAIR: begin
        send_command(CMD_ALLOC, rand_id(), pool_mac(), rand_st());
        if (last_answer.found && $urandom_range(0, 7) != 0)
          send_command(CMD_SET_STATUS, last_answer.result_id, rand_mac(),
                       ST_W'($urandom_range(1, 7)));
      end
      MIX_LOOKUP:     send_command(CMD_LOOKUP, rand_id(), pool_mac(), rand_st());
      MIX_UNREG_MAC:  send_command(CMD_UNREG_MAC, rand_id(), pool_mac(), rand_st());
      MIX_UNREG_ID:   send_command(CMD_UNREG_ID, rand_id(), rand_mac(), rand_st());
      MIX_COUNT:      send_command(CMD_COUNT, rand_id(), rand_mac(), rand_st());
      MIX_NEXT:       send_command(CMD_NEXT, rand_id(), rand_mac(), rand_st());
      MIX_SET_STATUS: send_command(CMD_SET_STATUS, rand_id(), rand_mac(), rand_st());
      MIX_READ:       send_command(CMD_READ, rand_id(), rand_mac(), rand_st());
      default:        send_command(cmd_t'($urandom_range(0, 7)), rand_id(), rand_mac(),
                                   rand_st());
    endcase
  endtask

  // result side: random stalls, every result transfer is checked
  initial begin
    int unsigned stall;
    bit          steady;
    steady = 1'b0;
    @(posedge rst_n);
    forever begin
      stall = steady ? 0 : $urandom_range(0, 10);
      repeat (stall) begin
        @(negedge clk);
        out_tready <= 1'b0;
      end
      @(negedge clk);
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      table_model.check_answer(out_tdata);
      if ($urandom_range(0, 63) == 0) steady = !steady;
    end
  end

  // stimulus and verdict
  initial begin
    int unsigned next_pause;
    int unsigned last_item;
    table_model = new(SLOTS);
    mac_pool[0] = '0;
    mac_pool[1] = '1;
    for (int k = 2; k < POOL_SIZE; k++) mac_pool[k] = rand_mac();

    repeat (2) @(negedge clk);
    rst_n <= 1'b1;

    // directed: empty table, registering the all-ones and the all-zero mac, walks and clears
    send_command(CMD_READ, 5'd0, rand_mac(), rand_st());
    send_command(CMD_READ, 5'd31, rand_mac(), rand_st());
    send_command(CMD_COUNT, rand_id(), rand_mac(), rand_st());
    send_command(CMD_LOOKUP, rand_id(), '0, rand_st());
    send_command(CMD_NEXT, 5'd0, rand_mac(), rand_st());
    send_command(CMD_ALLOC, rand_id(), '1, rand_st());
    send_command(CMD_LOOKUP, rand_id(), '1, rand_st());
    send_command(CMD_SET_STATUS, 5'd0, rand_mac(), 3'd7);
    send_command(CMD_LOOKUP, rand_id(), '1, rand_st());
    send_command(CMD_ALLOC, rand_id(), '1, rand_st());
    send_command(CMD_ALLOC, rand_id(), '0, rand_st());
    send_command(CMD_SET_STATUS, 5'd1, rand_mac(), 3'd1);
    send_command(CMD_LOOKUP, rand_id(), '0, rand_st());
    send_command(CMD_SET_STATUS, 5'd31, rand_mac(), 3'd4);
    send_command(CMD_NEXT, 5'd0, rand_mac(), rand_st());
    send_command(CMD_NEXT, 5'd1, rand_mac(), rand_st());
    send_command(CMD_NEXT, 5'd31, rand_mac(), rand_st());
    send_command(CMD_COUNT, rand_id(), rand_mac(), rand_st());
    send_command(CMD_UNREG_MAC, rand_id(), '0, rand_st());
    send_command(CMD_UNREG_ID, 5'd1, rand_mac(), rand_st());
    send_command(CMD_UNREG_ID, 5'd0, rand_mac(), rand_st());
    send_command(CMD_UNREG_MAC, rand_id(), 48'h1234_5678_9abc, rand_st());
    send_command(CMD_SET_STATUS, 5'd31, rand_mac(), 3'd0);
    send_command(CMD_READ, 5'd31, rand_mac(), rand_st());
    send_command(CMD_COUNT, rand_id(), rand_mac(), rand_st());
    drain_answers();

    // random mix in rotating fill, drain and mixed phases
    last_item  = sent_items + RANDOM_ITEMS;
    next_pause = sent_items + PAUSE_EVERY;
    while (sent_items < last_item) begin
      if (sent_items >= next_pause) begin
        drain_answers();
        next_pause += PAUSE_EVERY;
      end
      random_step(phase_t'((sent_items / PHASE_LEN) % 3));
    end

    drain_answers();
    repeat (SLOTS + 8) @(posedge clk);
    if (table_model.mismatches == 0 && table_model.pending() == 0) begin
      $display("mac_keyed_node_table_core_tb OK");
    end else begin
      $display("mac_keyed_node_table_core_tb NOT OK");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2000000;
    $display("mac_keyed_node_table_core_tb NOT OK");
    $finish;
  end

endmodule
